>>> design/tbr_pkg.sv
package tbr_pkg;

  localparam int MAX_SPEED_DEF = 4;
  localparam logic [15:0] PERIOD_RESET = 16'd67;

  localparam int CMD_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // cmd codes
  localparam logic [2:0] CMD_HOT_KEY = 3'd0;
  localparam logic [2:0] CMD_PAD = 3'd1;
  localparam logic [2:0] CMD_TICK = 3'd2;
  localparam logic [2:0] CMD_RELEASE_ALL = 3'd3;
  localparam logic [2:0] CMD_SET_SPEED = 3'd4;

  // hot key codes
  localparam logic [2:0] KEY_FAST = 3'd0;
  localparam logic [2:0] KEY_SHOT = 3'd1;
  localparam logic [2:0] KEY_ESCAPE = 3'd2;
  localparam logic [2:0] KEY_RESET = 3'd3;
  localparam logic [2:0] KEY_TURBO = 3'd4;

  // register indexes
  localparam logic [1:0] CFG_MACRO_MODE = 2'd0;
  localparam logic [1:0] CFG_INPUT_BLOCKED = 2'd1;
  localparam logic [1:0] CFG_SPEED_KEYS = 2'd2;
  localparam logic [1:0] CFG_TOGGLE_PERIOD = 2'd3;

  // input beat, lowest field last
  typedef struct packed {
    logic       fill;
    logic [2:0] speed_value;
    logic [7:0] pad2_release;
    logic [7:0] pad2_press;
    logic [7:0] pad1_release;
    logic [7:0] pad1_press;
    logic       key_down;
    logic [2:0] hot_key;
  } in_beat_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       macro_toggle;
    logic       reset_request;
    logic       escape_request;
    logic       shot_request;
    logic       speed_changed;
    logic       capturing;
    logic       turbo_on;
    logic [2:0] speed_now;
    logic [7:0] pad2_applied;
    logic [7:0] pad1_applied;
  } out_beat_t;

  localparam int IN_W = $bits(in_beat_t);
  localparam int OUT_W = $bits(out_beat_t);

endpackage

>>> design/turbo_button_router.sv
// Turbo button router for two 8-button pads. Decoded events arrive as one beat
// each (tuser selects hot key, pad masks, 1 ms tick, release all or set speed);
// every input beat yields exactly one result beat with the applied pad masks,
// the hold/capture flags, the speed multiplier and one-beat request pulses.
// Throughput is one beat per clock unless the result side stalls: a beat is
// held in the input register, the state update and result are a single pass
// of mask logic into the result register, and both registers advance together
// whenever the result register is empty or being taken.
module turbo_button_router #(
  parameter int MAX_SPEED = tbr_pkg::MAX_SPEED_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // hot_key, key_down, pad1_press, pad1_release, pad2_press, pad2_release,
  // speed_value
  input  logic [tbr_pkg::IN_W-1:0]     s_axis_tdata,
  // cmd
  input  logic [tbr_pkg::CMD_W-1:0]    s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // pad1_applied, pad2_applied, speed_now, turbo_on, capturing, speed_changed,
  // shot_request, escape_request, reset_request, macro_toggle
  output logic [tbr_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                         cfg_we,
  input  logic [tbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tbr_pkg::*;

  localparam logic [2:0] SPEED_MAX = 3'(MAX_SPEED);

  logic        macro_mode, input_blocked, speed_keys_enabled;
  logic [15:0] toggle_period_ms;

  logic [7:0]  pad1_normal, pad2_normal, pad1_turbo, pad2_turbo;
  logic        hold_active, capture_active, phase_on;
  logic [15:0] since_toggle;
  logic [2:0]  speed_level;

  logic [7:0]  pad1_normal_next, pad2_normal_next, pad1_turbo_next, pad2_turbo_next;
  logic        hold_active_next, capture_active_next, phase_on_next;
  logic [15:0] since_toggle_next, since_inc;
  logic [2:0]  speed_level_next;

  logic        in_vld;
  in_beat_t    in_reg;
  logic [2:0]  cmd_reg;
  out_beat_t   res, out_reg;
  logic        out_free, advance;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign advance = in_vld && out_free;
  assign s_axis_tready = !in_vld || out_free;
  assign m_axis_tdata = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      macro_mode <= 1'b0;
      input_blocked <= 1'b0;
      speed_keys_enabled <= 1'b1;
      toggle_period_ms <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MACRO_MODE: macro_mode <= cfg_data[0];
        CFG_INPUT_BLOCKED: input_blocked <= cfg_data[0];
        CFG_SPEED_KEYS: speed_keys_enabled <= cfg_data[0];
        CFG_TOGGLE_PERIOD: toggle_period_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pad1_normal_next = pad1_normal;
    pad2_normal_next = pad2_normal;
    pad1_turbo_next = pad1_turbo;
    pad2_turbo_next = pad2_turbo;
    hold_active_next = hold_active;
    capture_active_next = capture_active;
    phase_on_next = phase_on;
    since_toggle_next = since_toggle;
    speed_level_next = speed_level;
    since_inc = (since_toggle == 16'hFFFF) ? since_toggle : since_toggle + 16'd1;
    res = '0;

    case (cmd_reg)
      CMD_HOT_KEY: begin
        case (in_reg.hot_key)
          KEY_FAST: begin
            if (speed_keys_enabled && in_reg.key_down) begin
              speed_level_next = (speed_level >= SPEED_MAX) ? 3'd1 : speed_level + 3'd1;
              res.speed_changed = 1'b1;
            end
          end
          KEY_SHOT: res.shot_request = in_reg.key_down;
          KEY_ESCAPE: res.escape_request = in_reg.key_down;
          KEY_RESET: res.reset_request = in_reg.key_down;
          KEY_TURBO: begin
            if (speed_keys_enabled) begin
              if (macro_mode) begin
                res.macro_toggle = in_reg.key_down;
              end else begin
                if (in_reg.key_down) begin
                  if (hold_active && !capture_active) begin
                    hold_active_next = 1'b0;
                  end else begin
                    capture_active_next = 1'b1;
                    phase_on_next = 1'b1;
                    since_toggle_next = '0;
                  end
                end else begin
                  capture_active_next = 1'b0;
                  if ((pad1_turbo | pad2_turbo) == 8'd0) hold_active_next = 1'b0;
                end
                if (!hold_active_next) begin
                  pad1_turbo_next = '0;
                  pad2_turbo_next = '0;
                end
              end
            end
          end
          default: ;
        endcase
      end
      CMD_PAD: begin
        if (((in_reg.pad1_press | in_reg.pad1_release | in_reg.pad2_press |
              in_reg.pad2_release) != 8'd0) && !input_blocked) begin
          pad1_normal_next = (pad1_normal | in_reg.pad1_press) & ~in_reg.pad1_release;
          pad2_normal_next = (pad2_normal | in_reg.pad2_press) & ~in_reg.pad2_release;
          if (capture_active) begin
            pad1_turbo_next = pad1_turbo | in_reg.pad1_press;
            pad2_turbo_next = pad2_turbo | in_reg.pad2_press;
            if ((in_reg.pad1_press | in_reg.pad2_press) != 8'd0) hold_active_next = 1'b1;
            pad1_normal_next = pad1_normal_next & ~pad1_turbo_next;
            pad2_normal_next = pad2_normal_next & ~pad2_turbo_next;
          end
        end
      end
      CMD_TICK: begin
        since_toggle_next = since_inc;
        if (hold_active && ((pad1_turbo | pad2_turbo) != 8'd0) &&
            since_inc >= toggle_period_ms) begin
          since_toggle_next = '0;
          phase_on_next = !phase_on;
        end
      end
      CMD_RELEASE_ALL: begin
        pad1_normal_next = '0;
        pad2_normal_next = '0;
        pad1_turbo_next = '0;
        pad2_turbo_next = '0;
        hold_active_next = 1'b0;
        capture_active_next = 1'b0;
        phase_on_next = 1'b1;
        speed_level_next = 3'd1;
      end
      CMD_SET_SPEED: begin
        speed_level_next = (in_reg.speed_value >= 3'd1 && in_reg.speed_value <= SPEED_MAX) ?
                           in_reg.speed_value : 3'd1;
      end
      default: ;
    endcase

    res.pad1_applied = pad1_normal_next |
                       ((hold_active_next && phase_on_next) ? pad1_turbo_next : 8'd0);
    res.pad2_applied = pad2_normal_next |
                       ((hold_active_next && phase_on_next) ? pad2_turbo_next : 8'd0);
    res.speed_now = speed_level_next;
    res.turbo_on = hold_active_next;
    res.capturing = capture_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
      m_axis_tvalid <= 1'b0;
      pad1_normal <= '0;
      pad2_normal <= '0;
      pad1_turbo <= '0;
      pad2_turbo <= '0;
      hold_active <= 1'b0;
      capture_active <= 1'b0;
      phase_on <= 1'b1;
      since_toggle <= '0;
      speed_level <= 3'd1;
    end else begin
      if (s_axis_tready) in_vld <= s_axis_tvalid;
      if (out_free) m_axis_tvalid <= in_vld;
      if (advance) begin
        pad1_normal <= pad1_normal_next;
        pad2_normal <= pad2_normal_next;
        pad1_turbo <= pad1_turbo_next;
        pad2_turbo <= pad2_turbo_next;
        hold_active <= hold_active_next;
        capture_active <= capture_active_next;
        phase_on <= phase_on_next;
        since_toggle <= since_toggle_next;
        speed_level <= speed_level_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_reg <= in_beat_t'(s_axis_tdata);
      cmd_reg <= s_axis_tuser;
    end
    if (advance) out_reg <= res;
  end

endmodule

>>> design/tbr_checker.sv
module tbr_checker #(
  parameter int MAX_SPEED = tbr_pkg::MAX_SPEED_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [tbr_pkg::OUT_W-1:0] m_axis_tdata
);
  import tbr_pkg::*;

  out_beat_t beat;
  logic [4:0] pulses;

  assign beat = out_beat_t'(m_axis_tdata);
  assign pulses = {beat.macro_toggle, beat.reset_request, beat.escape_request,
                   beat.shot_request, beat.speed_changed};

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (beat.speed_now >= 3'd1 && beat.speed_now <= 3'(MAX_SPEED)))
    else $error("speed_now out of range");

  // one event per beat, so at most one request pulse
  a_one_pulse: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot0(pulses))
    else $error("more than one request pulse in a beat");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result beat changed");

endmodule

bind turbo_button_router tbr_checker #(.MAX_SPEED(MAX_SPEED)) u_tbr_checker (
  .clk(clk),
  .rst(rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

>>> test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbr_pkg::*;

  localparam int LIMIT = 300000;

  typedef struct {
    logic [2:0] cmd;
    in_beat_t   beat;
  } pad_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic [CMD_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  turbo_button_router uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // router mirror: config
  logic        macro_on = 1'b0;
  logic        blocked = 1'b0;
  logic        keys_on = 1'b1;
  logic [15:0] period = PERIOD_RESET;
  // router mirror: state
  logic [7:0]  norm1 = '0;
  logic [7:0]  norm2 = '0;
  logic [7:0]  turbo1 = '0;
  logic [7:0]  turbo2 = '0;
  logic        hold = 1'b0;
  logic        capture = 1'b0;
  logic        phase = 1'b1;
  logic [15:0] since_ms = '0;
  logic [2:0]  speed_lv = 3'd1;

  pad_event_t event_backlog[$];
  pad_event_t in_flight;
  out_beat_t  routed_due[$];
  out_beat_t  want_r;
  out_beat_t  got_r;
  int         queued = 0;
  int         fails = 0;
  int         cycles = 0;
  logic       calm = 1'b0;

  function automatic out_beat_t route_event(input logic [2:0] cmd, input in_beat_t b);
    out_beat_t r;
    r = '0;
    case (cmd)
      CMD_HOT_KEY: begin
        case (b.hot_key)
          KEY_FAST: begin
            if (keys_on && b.key_down) begin
              speed_lv = (speed_lv >= MAX_SPEED_DEF) ? 3'd1 : speed_lv + 3'd1;
              r.speed_changed = 1'b1;
            end
          end
          KEY_SHOT: r.shot_request = b.key_down;
          KEY_ESCAPE: r.escape_request = b.key_down;
          KEY_RESET: r.reset_request = b.key_down;
          KEY_TURBO: begin
            if (keys_on && macro_on) begin
              r.macro_toggle = b.key_down;
            end else if (keys_on) begin
              if (b.key_down) begin
                if (hold && !capture) begin
                  hold = 1'b0;
                end else begin
                  capture = 1'b1;
                  phase = 1'b1;
                  since_ms = '0;
                end
              end else begin
                capture = 1'b0;
                if (turbo1 == 8'h00 && turbo2 == 8'h00) hold = 1'b0;
              end
              if (!hold) begin
                turbo1 = '0;
                turbo2 = '0;
              end
            end
          end
          default: ;
        endcase
      end
      CMD_PAD: begin
        if ((b.pad1_press | b.pad1_release | b.pad2_press | b.pad2_release) != 8'h00 &&
            !blocked) begin
          norm1 = (norm1 | b.pad1_press) & ~b.pad1_release;
          norm2 = (norm2 | b.pad2_press) & ~b.pad2_release;
          if (capture) begin
            // buttons pressed while capturing move to the turbo set
            turbo1 = turbo1 | b.pad1_press;
            turbo2 = turbo2 | b.pad2_press;
            if ((b.pad1_press | b.pad2_press) != 8'h00) hold = 1'b1;
            norm1 = norm1 & ~turbo1;
            norm2 = norm2 & ~turbo2;
          end
        end
      end
      CMD_TICK: begin
        if (since_ms != 16'hFFFF) since_ms = since_ms + 16'd1;
        if (hold && (turbo1 | turbo2) != 8'h00 && since_ms >= period) begin
          since_ms = '0;
          phase = !phase;
        end
      end
      CMD_RELEASE_ALL: begin
        norm1 = '0;
        norm2 = '0;
        turbo1 = '0;
        turbo2 = '0;
        hold = 1'b0;
        capture = 1'b0;
        phase = 1'b1;
        speed_lv = 3'd1;
      end
      CMD_SET_SPEED: begin
        speed_lv = (b.speed_value >= 1 && b.speed_value <= MAX_SPEED_DEF) ?
                   b.speed_value : 3'd1;
      end
      default: ;
    endcase
    r.pad1_applied = norm1 | ((hold && phase) ? turbo1 : 8'h00);
    r.pad2_applied = norm2 | ((hold && phase) ? turbo2 : 8'h00);
    r.speed_now = speed_lv;
    r.turbo_on = hold;
    r.capturing = capture;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        routed_due.push_back(route_event(in_flight.cmd, in_flight.beat));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (event_backlog.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
          in_flight = event_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= in_flight.beat;
          s_axis_tuser <= in_flight.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (routed_due.size() == 0) begin
          $error("result beat with nothing expected: %h", m_axis_tdata);
          fails++;
        end else begin
          want_r = routed_due.pop_front();
          got_r = m_axis_tdata;
          check_field("pad1_applied", want_r.pad1_applied, got_r.pad1_applied);
          check_field("pad2_applied", want_r.pad2_applied, got_r.pad2_applied);
          check_field("speed_now", 8'(want_r.speed_now), 8'(got_r.speed_now));
          check_field("turbo_on", 8'(want_r.turbo_on), 8'(got_r.turbo_on));
          check_field("capturing", 8'(want_r.capturing), 8'(got_r.capturing));
          check_field("speed_changed", 8'(want_r.speed_changed), 8'(got_r.speed_changed));
          check_field("shot_request", 8'(want_r.shot_request), 8'(got_r.shot_request));
          check_field("escape_request", 8'(want_r.escape_request),
                      8'(got_r.escape_request));
          check_field("reset_request", 8'(want_r.reset_request), 8'(got_r.reset_request));
          check_field("macro_toggle", 8'(want_r.macro_toggle), 8'(got_r.macro_toggle));
        end
      end
      m_axis_tready <= calm || $urandom_range(99) >= 28;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic in_beat_t rand_beat();
    logic [63:0] w;
    in_beat_t b;
    w = {$urandom, $urandom};
    b = w[IN_W-1:0];
    return b;
  endfunction

  function automatic in_beat_t key_beat(input logic [2:0] k, input logic d);
    in_beat_t b;
    b = '0;
    b.hot_key = k;
    b.key_down = d;
    return b;
  endfunction

  function automatic in_beat_t pad_beat(input logic [7:0] p1p, input logic [7:0] p1r,
                                        input logic [7:0] p2p, input logic [7:0] p2r);
    in_beat_t b;
    b = '0;
    b.pad1_press = p1p;
    b.pad1_release = p1r;
    b.pad2_press = p2p;
    b.pad2_release = p2r;
    return b;
  endfunction

  task automatic push_ev(input logic [2:0] c, input in_beat_t b);
    pad_event_t e;
    e.cmd = c;
    e.beat = b;
    e.beat.fill = 1'b0;
    event_backlog.push_back(e);
    queued++;
  endtask

  task automatic set_regs(input logic m, input logic bl, input logic k, input logic [15:0] p);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MACRO_MODE;
    cfg_data <= {15'd0, m};
    macro_on = m;
    @(posedge clk);
    cfg_index <= CFG_INPUT_BLOCKED;
    cfg_data <= {15'd0, bl};
    blocked = bl;
    @(posedge clk);
    cfg_index <= CFG_SPEED_KEYS;
    cfg_data <= {15'd0, k};
    keys_on = k;
    @(posedge clk);
    cfg_index <= CFG_TOGGLE_PERIOD;
    cfg_data <= p;
    period = p;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every beat has gone through and its result has been checked
  task automatic drain();
    do @(negedge clk);
    while (event_backlog.size() != 0 || s_axis_tvalid || routed_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_phase(input int n, input int max_ticks);
    int stop;
    int pick;
    in_beat_t b;
    stop = queued + n;
    while (queued < stop) begin
      pick = $urandom_range(99);
      b = rand_beat();
      if (pick < 30) begin
        repeat ($urandom_range(max_ticks, 1)) push_ev(CMD_TICK, rand_beat());
      end else if (pick < 45) begin
        // capture sequence: turbo down, some presses, turbo up
        b.hot_key = KEY_TURBO;
        b.key_down = 1'b1;
        push_ev(CMD_HOT_KEY, b);
        repeat ($urandom_range(3, 1)) push_ev(CMD_PAD, rand_beat());
        b = rand_beat();
        b.hot_key = KEY_TURBO;
        b.key_down = 1'b0;
        push_ev(CMD_HOT_KEY, b);
      end else if (pick < 60) begin
        if ($urandom_range(1)) b.pad1_press = '0;
        if ($urandom_range(1)) b.pad1_release = '0;
        if ($urandom_range(1)) b.pad2_press = '0;
        if ($urandom_range(1)) b.pad2_release = '0;
        push_ev(CMD_PAD, b);
      end else if (pick < 70) begin
        b.hot_key = KEY_TURBO;
        push_ev(CMD_HOT_KEY, b);
      end else if (pick < 82) begin
        push_ev(CMD_HOT_KEY, b);
      end else if (pick < 88) begin
        push_ev(CMD_RELEASE_ALL, b);
      end else if (pick < 94) begin
        push_ev(CMD_SET_SPEED, b);
      end else begin
        push_ev(3'($urandom_range(7, 5)), b);
      end
    end
  endtask

  initial begin
    in_beat_t b;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_regs(1'b0, 1'b0, 1'b1, 16'd1);

    // directed: speed wrap, pulses, bad selectors, pad edges, one turbo cycle
    push_ev(CMD_HOT_KEY, key_beat(KEY_FAST, 1'b1));
    push_ev(CMD_HOT_KEY, key_beat(KEY_FAST, 1'b0));
    repeat (3) push_ev(CMD_HOT_KEY, key_beat(KEY_FAST, 1'b1));
    push_ev(CMD_HOT_KEY, key_beat(KEY_SHOT, 1'b1));
    push_ev(CMD_HOT_KEY, key_beat(KEY_ESCAPE, 1'b1));
    push_ev(CMD_HOT_KEY, key_beat(KEY_RESET, 1'b1));
    push_ev(CMD_HOT_KEY, key_beat(KEY_RESET, 1'b0));
    push_ev(CMD_HOT_KEY, key_beat(3'd7, 1'b1));
    push_ev(3'd7, rand_beat());
    b = '0;
    b.speed_value = 3'd7;
    push_ev(CMD_SET_SPEED, b);
    b.speed_value = 3'd4;
    push_ev(CMD_SET_SPEED, b);
    b.speed_value = 3'd0;
    push_ev(CMD_SET_SPEED, b);
    push_ev(CMD_PAD, pad_beat(8'h00, 8'h00, 8'h00, 8'h00));
    push_ev(CMD_PAD, pad_beat(8'hFF, 8'h00, 8'hFF, 8'h00));
    push_ev(CMD_PAD, pad_beat(8'h00, 8'hF0, 8'h00, 8'h0F));
    push_ev(CMD_HOT_KEY, key_beat(KEY_TURBO, 1'b1));
    push_ev(CMD_PAD, pad_beat(8'h81, 8'h00, 8'h18, 8'h00));
    push_ev(CMD_HOT_KEY, key_beat(KEY_TURBO, 1'b0));
    push_ev(CMD_TICK, '0);
    push_ev(CMD_TICK, '0);
    push_ev(CMD_HOT_KEY, key_beat(KEY_TURBO, 1'b1));
    push_ev(CMD_RELEASE_ALL, '0);
    drain();

    // no idling on either side here
    set_regs(1'b0, 1'b0, 1'b1, 16'd3);
    calm = 1'b1;
    random_phase(200, 8);
    drain();
    calm = 1'b0;

    // zero period behaves as one
    set_regs(1'b1, 1'b0, 1'b1, 16'd0);
    random_phase(100, 6);
    drain();

    set_regs(1'b0, 1'b1, 1'b0, 16'hFFFF);
    random_phase(80, 6);
    drain();

    set_regs(1'b0, 1'b0, 1'b1, PERIOD_RESET);
    random_phase(150, 40);
    drain();

    set_regs(1'b0, 1'b0, 1'b1, 16'd2);
    random_phase(220, 8);
    drain();

    if (fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
